FILE: design/api_receive_frame_parser_unit_assert.svh
// Assertion macros used by the frame parser top level.
`ifndef API_RECEIVE_FRAME_PARSER_UNIT_ASSERT_SVH
`define API_RECEIVE_FRAME_PARSER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define ARFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define ARFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ARFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: design/arfp_pkg.sv
// Types and constants of the receive frame parser.
package arfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 17;
    localparam int SIZE_W   = IDX_W + 1;
    localparam int LEN_W    = 16;
    localparam int CFG_IDX_W = 8;

    localparam logic [IDX_W-1:0]  IDX_MAX        = 17'h1FFFF;
    localparam logic [IDX_W-1:0]  OFS_DELIM      = 17'd0;
    localparam logic [IDX_W-1:0]  OFS_LEN_HI     = 17'd1;
    localparam logic [IDX_W-1:0]  OFS_LEN_LO     = 17'd2;
    localparam logic [IDX_W-1:0]  OFS_TYPE       = 17'd3;
    localparam logic [IDX_W-1:0]  PAYLOAD_OFFSET = 17'd15;
    localparam logic [SIZE_W-1:0] MIN_SIZE       = 18'd16;
    localparam logic [SIZE_W-1:0] LEN_OVERHEAD   = 18'd4;
    localparam logic [BYTE_W-1:0] CSUM_BASE      = 8'hFF;

    localparam logic [BYTE_W-1:0] RST_START_DELIMITER = 8'h7E;
    localparam logic [BYTE_W-1:0] RST_FRAME_TYPE      = 8'h90;

    localparam logic [CFG_IDX_W-1:0] CFG_START_DELIMITER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE      = 8'd1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_DELIM = 3'd2,
        ST_LEN   = 3'd3,
        ST_TYPE  = 3'd4,
        ST_CSUM  = 3'd5
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        logic              frame_done;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic [BYTE_W-1:0] start_delimiter;
        logic [BYTE_W-1:0] expected_frame_type;
    } t_cfg;

endpackage

FILE: design/arfp_ifs.sv
// Channel interfaces of the receive frame parser.
interface arfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       end_of_frame;

    modport source (output valid, output frame_byte, output end_of_frame, input ready);
    modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface arfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    logic [2:0] status;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_done, output status, input ready);
    modport sink (input valid, input payload_byte, input payload_valid,
                  input frame_done, input status, output ready);
endinterface

interface arfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/api_receive_frame_parser_unit.sv
// Top level of the receive frame parser.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------------
//  i_in     | in  | valid / ready | frame_byte[7:0], end_of_frame
//  o_out    | out | valid / ready | payload_byte[7:0], payload_valid, frame_done,
//           |     |               | status[2:0]
//  i_cfg    | in  | valid / ready | index[7:0], data[7:0]; ready always high
//
// One byte per cycle while the result register is not stalled: a byte waits in the input
// register, the checks and frame state update run in one combinational step into the result register.
// A byte causing no result passes even while the result register is stalled.
// Synchronous active-low reset clears control and frame state; registers return to
// delimiter 0x7E and frame type 0x90.
`include "api_receive_frame_parser_unit_assert.svh"

module api_receive_frame_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    arfp_in_if.sink    i_in,
    arfp_out_if.source o_out,
    arfp_cfg_if.sink   i_cfg
);

    arfp_pkg::t_in_item in_item;
    arfp_pkg::t_in_item stage_item;
    arfp_pkg::t_cfg     cfg;
    arfp_pkg::t_result  parse_result;
    arfp_pkg::t_result  out_result;
    logic               stage_valid;
    logic               advance;
    logic               load;
    logic               out_free;
    logic               out_valid;

    assign in_item.frame_byte   = i_in.frame_byte;
    assign in_item.end_of_frame = i_in.end_of_frame;
    assign i_cfg.ready          = 1'b1;

    arfp_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid && i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    arfp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (i_in.ready),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    arfp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stage_valid),
        .i_item     (stage_item),
        .i_cfg      (cfg),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_load     (load),
        .o_result   (parse_result)
    );

    arfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (parse_result),
        .i_ready  (o_out.ready),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_out.valid         = out_valid;
    assign o_out.payload_byte  = out_result.payload_byte;
    assign o_out.payload_valid = out_result.payload_valid;
    assign o_out.frame_done    = out_result.frame_done;
    assign o_out.status        = out_result.status;

    `ARFP_ASSERT_IMPL(a_mid_frame_carries_payload, i_clk, i_rst_n,
        out_valid && !out_result.frame_done, out_result.payload_valid,
        "mid-frame result without payload")
    `ARFP_ASSERT_IMPL(a_status_only_on_done, i_clk, i_rst_n,
        out_valid && !out_result.frame_done, out_result.status == arfp_pkg::ST_OK,
        "status set on mid-frame result")
    `ARFP_ASSERT_NEXT(a_stalled_byte_kept, i_clk, i_rst_n,
        stage_valid && !advance, stage_valid && $stable(stage_item),
        "stalled byte lost from input register")
    `ARFP_ASSERT_IMPL(a_load_needs_space, i_clk, i_rst_n, load, out_free,
        "result loaded over an untaken result")

endmodule

FILE: design/arfp_cfg_regs.sv
// Configuration registers: start delimiter and expected frame type.
module arfp_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [arfp_pkg::CFG_IDX_W-1:0]       i_wr_index,
    input  logic [arfp_pkg::BYTE_W-1:0]          i_wr_data,
    output arfp_pkg::t_cfg                       o_cfg
);

    arfp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delimiter     <= arfp_pkg::RST_START_DELIMITER;
            r_cfg.expected_frame_type <= arfp_pkg::RST_FRAME_TYPE;
        end else if (i_wr_en) begin
            // writes to unknown indexes are dropped
            if (i_wr_index == arfp_pkg::CFG_START_DELIMITER) begin
                r_cfg.start_delimiter <= i_wr_data;
            end else if (i_wr_index == arfp_pkg::CFG_FRAME_TYPE) begin
                r_cfg.expected_frame_type <= i_wr_data;
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/arfp_in_reg.sv
// Input register: holds one accepted byte until the parser takes it.
module arfp_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  arfp_pkg::t_in_item i_item,
    input  logic               i_advance,
    output logic               o_ready,
    output logic               o_valid,
    output arfp_pkg::t_in_item o_item
);

    logic               r_valid;
    arfp_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: design/arfp_parse.sv
// State and checks: one byte per cycle if output free; result combinational.
module arfp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  arfp_pkg::t_in_item i_item,
    input  arfp_pkg::t_cfg     i_cfg,
    input  logic               i_out_free,
    output logic               o_advance,
    output logic               o_load,
    output arfp_pkg::t_result  o_result
);

    logic [arfp_pkg::IDX_W-1:0]  r_byte_index, n_byte_index;
    logic [arfp_pkg::LEN_W-1:0]  r_header_length, n_header_length;
    logic                        r_delimiter_good, n_delimiter_good;
    logic                        r_type_good, n_type_good;
    logic [arfp_pkg::BYTE_W-1:0] r_running_sum, n_running_sum;
    logic [arfp_pkg::BYTE_W-1:0] r_held_byte, n_held_byte;
    logic                        r_held_is_payload, n_held_is_payload;

    logic                        produces;
    logic [arfp_pkg::SIZE_W-1:0] size;
    logic [arfp_pkg::SIZE_W-1:0] expected_size;
    logic                        delim_ok;
    logic                        type_ok;
    logic                        csum_ok;
    logic [arfp_pkg::BYTE_W-1:0] b;

    assign b         = i_item.frame_byte;
    assign produces  = i_item.end_of_frame || r_held_is_payload;
    // a byte with no result moves on even when the output is full
    assign o_advance = i_valid && (!produces || i_out_free);
    assign o_load    = o_advance && produces;

    assign size          = {1'b0, r_byte_index} + arfp_pkg::SIZE_W'(1);
    assign expected_size = {2'b00, r_header_length} + arfp_pkg::LEN_OVERHEAD;
    assign delim_ok = (r_byte_index == arfp_pkg::OFS_DELIM) ?
                      (b == i_cfg.start_delimiter) : r_delimiter_good;
    assign type_ok  = (r_byte_index == arfp_pkg::OFS_TYPE) ?
                      (b == i_cfg.expected_frame_type) : r_type_good;
    assign csum_ok  = ((arfp_pkg::CSUM_BASE - r_running_sum) == b);

    always_comb begin
        o_result.payload_byte  = r_held_is_payload ? r_held_byte : '0;
        o_result.payload_valid = r_held_is_payload;
        o_result.frame_done    = i_item.end_of_frame;
        o_result.status        = arfp_pkg::ST_OK;
        if (i_item.end_of_frame) begin
            // first failing check wins
            if (size < arfp_pkg::MIN_SIZE) begin
                o_result.status = arfp_pkg::ST_SHORT;
            end else if (!delim_ok) begin
                o_result.status = arfp_pkg::ST_DELIM;
            end else if (size != expected_size) begin
                o_result.status = arfp_pkg::ST_LEN;
            end else if (!type_ok) begin
                o_result.status = arfp_pkg::ST_TYPE;
            end else if (!csum_ok) begin
                o_result.status = arfp_pkg::ST_CSUM;
            end
        end
    end

    always_comb begin
        n_byte_index      = r_byte_index;
        n_header_length   = r_header_length;
        n_delimiter_good  = r_delimiter_good;
        n_type_good       = r_type_good;
        n_running_sum     = r_running_sum;
        n_held_byte       = r_held_byte;
        n_held_is_payload = r_held_is_payload;
        if (o_advance) begin
            if (i_item.end_of_frame) begin
                n_byte_index      = '0;
                n_header_length   = '0;
                n_delimiter_good  = 1'b0;
                n_type_good       = 1'b0;
                n_running_sum     = '0;
                n_held_byte       = '0;
                n_held_is_payload = 1'b0;
            end else begin
                if (r_byte_index == arfp_pkg::OFS_DELIM) begin
                    n_delimiter_good = (b == i_cfg.start_delimiter);
                end else if (r_byte_index == arfp_pkg::OFS_LEN_HI) begin
                    n_header_length = {b, r_header_length[7:0]};
                end else if (r_byte_index == arfp_pkg::OFS_LEN_LO) begin
                    n_header_length = {r_header_length[15:8], b};
                end else if (r_byte_index == arfp_pkg::OFS_TYPE) begin
                    n_type_good = (b == i_cfg.expected_frame_type);
                end
                if (r_byte_index >= arfp_pkg::OFS_TYPE) begin
                    n_running_sum = r_running_sum + b;
                end
                if (r_byte_index >= arfp_pkg::PAYLOAD_OFFSET) begin
                    n_held_byte       = b;
                    n_held_is_payload = 1'b1;
                end else begin
                    n_held_byte       = '0;
                    n_held_is_payload = 1'b0;
                end
                // saturate on overlong frames
                if (r_byte_index != arfp_pkg::IDX_MAX) begin
                    n_byte_index = r_byte_index + arfp_pkg::IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index      <= '0;
            r_header_length   <= '0;
            r_delimiter_good  <= 1'b0;
            r_type_good       <= 1'b0;
            r_running_sum     <= '0;
            r_held_byte       <= '0;
            r_held_is_payload <= 1'b0;
        end else begin
            r_byte_index      <= n_byte_index;
            r_header_length   <= n_header_length;
            r_delimiter_good  <= n_delimiter_good;
            r_type_good       <= n_type_good;
            r_running_sum     <= n_running_sum;
            r_held_byte       <= n_held_byte;
            r_held_is_payload <= n_held_is_payload;
        end
    end

endmodule

FILE: design/arfp_out_reg.sv
// Result register: holds one result until the sink takes it.
module arfp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  arfp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output arfp_pkg::t_result o_result
);

    logic              r_valid;
    arfp_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: tb/arfp_frame_audit.sv
`timescale 1ns / 100ps
// Frame parser audit: predicts every result from the accepted bytes and compares it with the block.
module arfp_frame_audit (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_run_done,
    arfp_in_if   i_bytes,
    arfp_out_if  i_results,
    arfp_cfg_if  i_regs,
    output int   o_fail_count,
    output int   o_awaited
);

    logic [arfp_pkg::BYTE_W-1:0] cfg_delim;
    logic [arfp_pkg::BYTE_W-1:0] cfg_type;

    logic [arfp_pkg::IDX_W-1:0]  frame_idx;
    logic [arfp_pkg::LEN_W-1:0]  len_field;
    logic                        delim_ok;
    logic                        type_ok;
    logic [arfp_pkg::BYTE_W-1:0] csum_acc;
    logic [arfp_pkg::BYTE_W-1:0] held;
    logic                        held_valid;

    arfp_pkg::t_result awaited_results[$];
    arfp_pkg::t_result want;

    int fails;
    int bytes_seen;
    int results_seen;
    int payload_seen;
    int longest;
    int status_tally[6];
    bit wrapped_up;

    assign o_fail_count = fails;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
        fails++;
        $display("%0t mismatch in %s: got %0h, want %0h", $time, what, got, wanted);
    endtask

    task automatic clear_frame();
        frame_idx  = '0;
        len_field  = '0;
        delim_ok   = 1'b0;
        type_ok    = 1'b0;
        csum_acc   = '0;
        held       = '0;
        held_valid = 1'b0;
    endtask

    task automatic parse_byte(input logic [arfp_pkg::BYTE_W-1:0] b, input logic last);
        arfp_pkg::t_result           r;
        arfp_pkg::t_status           st;
        logic [arfp_pkg::SIZE_W-1:0] size;
        logic [arfp_pkg::IDX_W-1:0]  i;
        i = frame_idx;
        bytes_seen++;
        if (last) begin
            size = {1'b0, i} + 18'd1;
            if (i == arfp_pkg::OFS_DELIM)
                delim_ok = (b == cfg_delim);
            if (i == arfp_pkg::OFS_TYPE)
                type_ok = (b == cfg_type);
            // first failing check wins
            if (size < arfp_pkg::MIN_SIZE)
                st = arfp_pkg::ST_SHORT;
            else if (!delim_ok)
                st = arfp_pkg::ST_DELIM;
            else if (size != {2'b00, len_field} + arfp_pkg::LEN_OVERHEAD)
                st = arfp_pkg::ST_LEN;
            else if (!type_ok)
                st = arfp_pkg::ST_TYPE;
            else if (8'(arfp_pkg::CSUM_BASE - csum_acc) != b)
                st = arfp_pkg::ST_CSUM;
            else
                st = arfp_pkg::ST_OK;
            r.payload_byte  = held_valid ? held : 8'h00;
            r.payload_valid = held_valid;
            r.frame_done    = 1'b1;
            r.status        = st;
            awaited_results = {awaited_results, r};
            status_tally[int'(st)]++;
            if (int'(size) > longest)
                longest = int'(size);
            clear_frame();
            return;
        end

        if (held_valid) begin
            r.payload_byte  = held;
            r.payload_valid = 1'b1;
            r.frame_done    = 1'b0;
            r.status        = arfp_pkg::ST_OK;
            awaited_results = {awaited_results, r};
        end

        if (i == arfp_pkg::OFS_DELIM)
            delim_ok = (b == cfg_delim);
        else if (i == arfp_pkg::OFS_LEN_HI)
            len_field[15:8] = b;
        else if (i == arfp_pkg::OFS_LEN_LO)
            len_field[7:0] = b;
        else if (i == arfp_pkg::OFS_TYPE)
            type_ok = (b == cfg_type);

        if (i >= arfp_pkg::OFS_TYPE)
            csum_acc = csum_acc + b;

        held_valid = (i >= arfp_pkg::PAYLOAD_OFFSET);
        held       = held_valid ? b : 8'h00;

        // saturate on overlong frames
        if (frame_idx < arfp_pkg::IDX_MAX)
            frame_idx = frame_idx + 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_delim = arfp_pkg::RST_START_DELIMITER;
            cfg_type  = arfp_pkg::RST_FRAME_TYPE;
            clear_frame();
            awaited_results.delete();
        end else begin
            if (i_regs.valid === 1'b1 && i_regs.ready === 1'b1) begin
                case (i_regs.index)
                    arfp_pkg::CFG_START_DELIMITER: cfg_delim = i_regs.data;
                    arfp_pkg::CFG_FRAME_TYPE:      cfg_type  = i_regs.data;
                    default: ;
                endcase
            end

            if (i_bytes.valid === 1'b1 && i_bytes.ready === 1'b1)
                parse_byte(i_bytes.frame_byte, i_bytes.end_of_frame);

            if (i_results.valid === 1'b1 && i_results.ready === 1'b1) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    flag_mismatch("unexpected result, payload byte", i_results.payload_byte, 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (want.payload_valid)
                        payload_seen++;
                    if (i_results.payload_byte !== want.payload_byte)
                        flag_mismatch("payload_byte", i_results.payload_byte, want.payload_byte);
                    if (i_results.payload_valid !== want.payload_valid)
                        flag_mismatch("payload_valid", i_results.payload_valid,
                                      want.payload_valid);
                    if (i_results.frame_done !== want.frame_done)
                        flag_mismatch("frame_done", i_results.frame_done, want.frame_done);
                    if (i_results.status !== want.status)
                        flag_mismatch("status", i_results.status, want.status);
                end
            end

            if (i_run_done === 1'b1 && !wrapped_up) begin
                wrapped_up = 1'b1;
                if (awaited_results.size() != 0)
                    flag_mismatch("results never delivered", 0, awaited_results.size());
                $display("covered %0d bytes, %0d results, %0d payload bytes, longest %0d",
                         bytes_seen, results_seen, payload_seen, longest);
                $display("frames: %0d ok, %0d short, %0d delim, %0d len, %0d type, %0d csum",
                         status_tally[int'(arfp_pkg::ST_OK)],
                         status_tally[int'(arfp_pkg::ST_SHORT)],
                         status_tally[int'(arfp_pkg::ST_DELIM)],
                         status_tally[int'(arfp_pkg::ST_LEN)],
                         status_tally[int'(arfp_pkg::ST_TYPE)],
                         status_tally[int'(arfp_pkg::ST_CSUM)]);
            end
        end
        o_awaited = awaited_results.size();
    end

endmodule

FILE: tb/tb_api_receive_frame_parser_unit.sv
`timescale 1ns / 100ps
// Testbench top of the receive frame parser: clock, reset, frame stimulus and verdict.
module tb_api_receive_frame_parser_unit;

    typedef enum int {
        SHAPE_CLEAN,
        SHAPE_MIXED,
        SHAPE_SHORT,
        SHAPE_NOISE
    } t_shape;

    logic i_clk;
    logic i_rst_n;
    logic run_done;
    int   audit_fails;
    int   audit_awaited;
    bit   quiet;
    int   bytes_sent;

    logic [arfp_pkg::BYTE_W-1:0] cur_delim;
    logic [arfp_pkg::BYTE_W-1:0] cur_type;

    arfp_in_if  byte_ch ();
    arfp_out_if result_ch ();
    arfp_cfg_if reg_ch ();

    api_receive_frame_parser_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (result_ch),
        .i_cfg   (reg_ch)
    );

    arfp_frame_audit u_audit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_run_done   (run_done),
        .i_bytes      (byte_ch),
        .i_results    (result_ch),
        .i_regs       (reg_ch),
        .o_fail_count (audit_fails),
        .o_awaited    (audit_awaited)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        return quiet ? 0 : int'($urandom_range(0, 9));
    endfunction

    // Result side: hold ready low for a random gap before each item.
    initial begin
        int hold;
        result_ch.ready = 1'b0;
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                @(negedge i_clk) result_ch.ready <= 1'b0;
                repeat (hold - 1) @(negedge i_clk);
            end
            @(negedge i_clk) result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (result_ch.valid !== 1'b1);
        end
    end

    task automatic send_byte(input logic [arfp_pkg::BYTE_W-1:0] value, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.frame_byte   <= value;
        byte_ch.end_of_frame <= last;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
    endtask

    // Drop valid and hold off until every predicted result has been delivered.
    task automatic settle(input int linger);
        @(negedge i_clk) byte_ch.valid <= 1'b0;
        wait (audit_awaited == 0);
        repeat (linger) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [arfp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arfp_pkg::BYTE_W-1:0] value);
        @(negedge i_clk);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= value;
        do @(posedge i_clk); while (reg_ch.ready !== 1'b1);
        @(negedge i_clk) reg_ch.valid <= 1'b0;
        if (idx == arfp_pkg::CFG_START_DELIMITER)
            cur_delim = value;
        else
            cur_type = value;
    endtask

    // span: payload length for well-formed shapes, whole size otherwise.
    // filler below zero means random filler bytes.
    task automatic make_frame(input t_shape shape, input int span, input int filler,
                              ref logic [arfp_pkg::BYTE_W-1:0] fb[$]);
        logic [arfp_pkg::LEN_W-1:0]  len;
        logic [arfp_pkg::BYTE_W-1:0] sum;
        logic [arfp_pkg::BYTE_W-1:0] next_byte;
        bit spoil_delim;
        bit spoil_len;
        bit spoil_type;
        bit spoil_csum;
        int total;
        fb.delete();
        if (shape == SHAPE_SHORT || shape == SHAPE_NOISE) begin
            next_byte = (shape == SHAPE_SHORT && $urandom_range(0, 1)) ?
                        cur_delim : 8'($urandom);
            fb = {fb, next_byte};
            repeat (span - 1) begin
                next_byte = filler < 0 ? 8'($urandom) : 8'(filler);
                fb = {fb, next_byte};
            end
            return;
        end
        spoil_delim = (shape == SHAPE_MIXED) && ($urandom_range(0, 5) == 0);
        spoil_len   = (shape == SHAPE_MIXED) && ($urandom_range(0, 5) == 0);
        spoil_type  = (shape == SHAPE_MIXED) && ($urandom_range(0, 5) == 0);
        spoil_csum  = (shape == SHAPE_MIXED) && ($urandom_range(0, 5) == 0);
        total = 16 + span;
        len = 16'(total - 4);
        if (spoil_len)
            len = $urandom_range(0, 1) ? 16'($urandom) : len ^ 16'($urandom_range(1, 3));
        next_byte = spoil_delim ? cur_delim ^ 8'($urandom_range(1, 255)) : cur_delim;
        fb = {fb, next_byte};
        fb = {fb, len[15:8]};
        fb = {fb, len[7:0]};
        next_byte = spoil_type ? cur_type ^ 8'($urandom_range(1, 255)) : cur_type;
        fb = {fb, next_byte};
        repeat (total - 5) begin
            next_byte = filler < 0 ? 8'($urandom) : 8'(filler);
            fb = {fb, next_byte};
        end
        sum = '0;
        for (int k = 3; k < total - 1; k++)
            sum = sum + fb[k];
        next_byte = 8'(arfp_pkg::CSUM_BASE - sum) ^
                    (spoil_csum ? 8'($urandom_range(1, 255)) : 8'h00);
        fb = {fb, next_byte};
    endtask

    task automatic send_frame(ref logic [arfp_pkg::BYTE_W-1:0] fb[$]);
        int pause_at;
        pause_at = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, fb.size() - 1)) : -1;
        foreach (fb[k]) begin
            if (k == pause_at)
                settle(0);
            send_byte(fb[k], k == fb.size() - 1);
        end
        bytes_sent += fb.size();
    endtask

    task automatic random_frames(input int byte_goal);
        logic [arfp_pkg::BYTE_W-1:0] fb[$];
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < byte_goal) begin
            quiet = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                make_frame(SHAPE_SHORT, $urandom_range(1, 15), -1, fb);
            else if (pick == 1)
                make_frame(SHAPE_NOISE, $urandom_range(1, 40), -1, fb);
            else
                make_frame(SHAPE_MIXED, ($urandom_range(0, 9) == 0) ?
                           $urandom_range(0, 200) : $urandom_range(0, 24), -1, fb);
            send_frame(fb);
        end
        quiet = 1'b0;
    endtask

    initial begin
        logic [arfp_pkg::BYTE_W-1:0] fb[$];

        i_rst_n              = 1'b0;
        run_done             = 1'b0;
        quiet                = 1'b0;
        bytes_sent           = 0;
        cur_delim            = arfp_pkg::RST_START_DELIMITER;
        cur_type             = arfp_pkg::RST_FRAME_TYPE;
        byte_ch.valid        = 1'b0;
        byte_ch.frame_byte   = '0;
        byte_ch.end_of_frame = 1'b0;
        reg_ch.valid         = 1'b0;
        reg_ch.index         = '0;
        reg_ch.data          = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // lone last byte, minimal clean frame of all-ones filler, short frame of zero filler
        // ending on the type offset
        make_frame(SHAPE_NOISE, 1, -1, fb);
        send_frame(fb);
        make_frame(SHAPE_CLEAN, 0, 255, fb);
        send_frame(fb);
        make_frame(SHAPE_SHORT, 4, 0, fb);
        send_frame(fb);

        random_frames(250);

        settle(6);
        write_reg(arfp_pkg::CFG_START_DELIMITER, 8'h00);
        write_reg(arfp_pkg::CFG_FRAME_TYPE, 8'h00);
        random_frames(250);

        settle(6);
        write_reg(arfp_pkg::CFG_START_DELIMITER, 8'hFF);
        write_reg(arfp_pkg::CFG_FRAME_TYPE, 8'hFF);
        random_frames(250);

        settle(6);
        write_reg(arfp_pkg::CFG_START_DELIMITER, 8'($urandom));
        write_reg(arfp_pkg::CFG_FRAME_TYPE, 8'($urandom));
        random_frames(250);

        settle(8);
        @(negedge i_clk) run_done <= 1'b1;
        @(negedge i_clk);
        if (audit_fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/arfp_pkg.sv
design/arfp_ifs.sv
design/arfp_cfg_regs.sv
design/arfp_in_reg.sv
design/arfp_parse.sv
design/arfp_out_reg.sv
design/api_receive_frame_parser_unit.sv
tb/arfp_frame_audit.sv
tb/tb_api_receive_frame_parser_unit.sv
